@@ rtl/sm4_pkg.sv @@
// Shared types, constants and the S-box table for the SM4 block cipher.
`timescale 1ns / 1ps

package sm4_pkg;

  localparam int unsigned NUM_ROUNDS = 32;
  localparam int unsigned KEY_IDX_W  = $clog2(NUM_ROUNDS);
  localparam int unsigned WORD_W     = 32;

  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_ENCRYPT = 2'd1;
  localparam logic [1:0] OP_DECRYPT = 2'd2;

  localparam logic [KEY_IDX_W-1:0] KEY_FIRST = '0;
  localparam logic [KEY_IDX_W-1:0] KEY_LAST  = KEY_IDX_W'(NUM_ROUNDS - 1);

  typedef struct packed {
    logic [1:0]           op;
    logic [KEY_IDX_W-1:0] key_index;
    logic [WORD_W-1:0]    key_word;
    logic [WORD_W-1:0]    in_word0;
    logic [WORD_W-1:0]    in_word1;
    logic [WORD_W-1:0]    in_word2;
    logic [WORD_W-1:0]    in_word3;
  } sm4_in_t;

  typedef struct packed {
    logic [WORD_W-1:0] out_word0;
    logic [WORD_W-1:0] out_word1;
    logic [WORD_W-1:0] out_word2;
    logic [WORD_W-1:0] out_word3;
  } sm4_out_t;

  // Key store write port.
  typedef struct packed {
    logic                 en;
    logic [KEY_IDX_W-1:0] addr;
    logic [WORD_W-1:0]    data;
  } sm4_key_wr_t;

  localparam logic [7:0] SBOX [256] = '{
    8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
    8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
    8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
    8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
    8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
    8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
    8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
    8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
    8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
    8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
    8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
    8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
    8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
    8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
    8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
  };

  function automatic logic [7:0] sbox(input logic [7:0] b);
    return SBOX[b];
  endfunction

endpackage

@@ rtl/sm4_key_mem.sv @@
// Round-key store: 32 x 32-bit synchronous memory, one write and one registered read port.
`timescale 1ns / 1ps

module sm4_key_mem (
  input  logic                          clk_i,
  input  sm4_pkg::sm4_key_wr_t          wr_i,
  input  logic [sm4_pkg::KEY_IDX_W-1:0] rd_addr_i,
  output logic [sm4_pkg::WORD_W-1:0]    rd_data_o
);
  import sm4_pkg::*;

  logic [WORD_W-1:0] mem_q [NUM_ROUNDS];
  logic [WORD_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ rtl/sm4_round.sv @@
// One SM4 round: X0 ^ T(X1 ^ X2 ^ X3 ^ rk), with T = S-box then linear map L.
`timescale 1ns / 1ps

module sm4_round (
  input  logic [sm4_pkg::WORD_W-1:0] x0_i,
  input  logic [sm4_pkg::WORD_W-1:0] x1_i,
  input  logic [sm4_pkg::WORD_W-1:0] x2_i,
  input  logic [sm4_pkg::WORD_W-1:0] x3_i,
  input  logic [sm4_pkg::WORD_W-1:0] rk_i,
  output logic [sm4_pkg::WORD_W-1:0] x4_o
);
  import sm4_pkg::*;

  logic [WORD_W-1:0] mix;
  logic [WORD_W-1:0] subst;
  logic [WORD_W-1:0] lin;

  assign mix = x1_i ^ x2_i ^ x3_i ^ rk_i;

  // Substitute each byte independently.
  always_comb begin
    for (int b = 0; b < 4; b++) begin
      subst[8*b +: 8] = sbox(mix[8*b +: 8]);
    end
  end

  assign lin = subst
             ^ {subst[29:0], subst[31:30]}
             ^ {subst[21:0], subst[31:22]}
             ^ {subst[13:0], subst[31:14]}
             ^ {subst[7:0],  subst[31:8]};

  assign x4_o = x0_i ^ lin;

endmodule

@@ rtl/sm4_block_cipher.sv @@
// Top level of the SM4 block cipher: round sequencer around the round-key store.
`timescale 1ns / 1ps

// Channel  Dir  Signals                               Transfer when
// -------  ---  ------------------------------------  ---------------------------
// in       in   in_valid_i, in_stall_o, in_data_i     in_valid_i && !in_stall_o
// out      out  out_valid_o, out_stall_i, out_data_o  out_valid_o && !out_stall_i
//
// A key load writes the word into the key store at the transfer edge.
// An encrypt or decrypt runs 32 rounds, one per cycle, each round using one key read
// from the single read port of the key store (read one round ahead). The last round
// loads the result into the output register; a new block is accepted only once the
// previous one has left the round registers for the output register.
// Reset clears the sequencer and the output valid; the key store has no reset and
// must be loaded before use.
// A stalled output holds the finished block in the round registers until the output
// register frees; in_stall_o stays high from an encrypt/decrypt transfer until then.

module sm4_block_cipher (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  sm4_pkg::sm4_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output sm4_pkg::sm4_out_t out_data_o
);
  import sm4_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_WAIT
  } state_e;

  state_e                state_q;
  logic [KEY_IDX_W-1:0]  round_q;
  logic                  dec_q;
  logic [WORD_W-1:0]     x_q [4];
  logic                  out_valid_q;
  logic                  out_valid_d;
  sm4_out_t              out_q;

  logic                  in_xfer;
  logic                  start;
  logic                  out_free;
  logic                  result_load;
  logic [KEY_IDX_W-1:0]  round_nxt;
  logic [KEY_IDX_W-1:0]  rd_addr;
  logic [WORD_W-1:0]     rk;
  logic [WORD_W-1:0]     x4;
  sm4_key_wr_t           key_wr;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign start      = in_xfer &&
                      ((in_data_i.op == OP_ENCRYPT) || (in_data_i.op == OP_DECRYPT));
  assign out_free   = !out_valid_q || !out_stall_i;
  assign round_nxt  = round_q + KEY_IDX_W'(1);

  // A finished block moves into the output register this cycle.
  assign result_load = out_free &&
                       (((state_q == ST_RUN) && (round_q == KEY_LAST)) ||
                        (state_q == ST_WAIT));

  // Drop the output once it transfers; a new result overrides this.
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (result_load) begin
      out_valid_d = 1'b1;
    end
  end

  assign key_wr.en   = in_xfer && (in_data_i.op == OP_LOAD);
  assign key_wr.addr = in_data_i.key_index;
  assign key_wr.data = in_data_i.key_word;

  // Prefetch the key of the next round; decrypt walks the store backwards.
  always_comb begin
    if (state_q == ST_IDLE) begin
      rd_addr = (in_data_i.op == OP_DECRYPT) ? KEY_LAST : KEY_FIRST;
    end else begin
      rd_addr = dec_q ? ~round_nxt : round_nxt;
    end
  end

  sm4_key_mem u_key_mem (
    .clk_i     (clk_i),
    .wr_i      (key_wr),
    .rd_addr_i (rd_addr),
    .rd_data_o (rk)
  );

  sm4_round u_round (
    .x0_i (x_q[0]),
    .x1_i (x_q[1]),
    .x2_i (x_q[2]),
    .x3_i (x_q[3]),
    .rk_i (rk),
    .x4_o (x4)
  );

  // Round words carry no reset.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE) begin
      if (start) begin
        x_q[0] <= in_data_i.in_word0;
        x_q[1] <= in_data_i.in_word1;
        x_q[2] <= in_data_i.in_word2;
        x_q[3] <= in_data_i.in_word3;
      end
    end else if (state_q == ST_RUN) begin
      // Shift the word window by one.
      x_q[0] <= x_q[1];
      x_q[1] <= x_q[2];
      x_q[2] <= x_q[3];
      x_q[3] <= x4;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      round_q     <= '0;
      dec_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      case (state_q)
        ST_IDLE: begin
          if (start) begin
            dec_q   <= (in_data_i.op == OP_DECRYPT);
            round_q <= '0;
            state_q <= ST_RUN;
          end
        end
        ST_RUN: begin
          round_q <= round_nxt;
          if (round_q == KEY_LAST) begin
            if (out_free) begin
              // Last round goes straight into the output register, words reversed.
              out_q.out_word0 <= x4;
              out_q.out_word1 <= x_q[3];
              out_q.out_word2 <= x_q[2];
              out_q.out_word3 <= x_q[1];
              state_q         <= ST_IDLE;
            end else begin
              state_q <= ST_WAIT;
            end
          end
        end
        ST_WAIT: begin
          if (out_free) begin
            out_q.out_word0 <= x_q[3];
            out_q.out_word1 <= x_q[2];
            out_q.out_word2 <= x_q[1];
            out_q.out_word3 <= x_q[0];
            state_q         <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The round counter wraps back to zero whenever a block completes.
  a_idle_round_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (round_q == '0))
    else $error("round counter not cleared in idle");

  // An encrypt or decrypt transfer starts the round sequence.
  a_start_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> (state_q == ST_RUN) && (round_q == '0))
    else $error("block transfer did not start rounds");

  // A new result appears only after the final round or from the wait state.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |->
      $past((state_q == ST_RUN && round_q == KEY_LAST) || state_q == ST_WAIT))
    else $error("result produced before all rounds finished");

  // No key is written while a block is in flight.
  a_no_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !key_wr.en)
    else $error("key store written during rounds");

endmodule

@@ dv/sm4_block_cipher_chk.sv @@
// Scoreboard for the SM4 block cipher: tracks the key store, predicts blocks, compares.
`timescale 1ns / 1ps

module sm4_block_cipher_chk (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  sm4_pkg::sm4_in_t  in_data_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  sm4_pkg::sm4_out_t out_data_i,
  output int                pending_o,
  output int                errors_o
);

  import sm4_pkg::*;

  logic [WORD_W-1:0] round_keys [NUM_ROUNDS];
  sm4_out_t          pending_blocks [$];
  int                mismatches = 0;

  // Byte substitution followed by the linear diffusion layer.
  function automatic logic [WORD_W-1:0] mix_word(input logic [WORD_W-1:0] a);
    logic [WORD_W-1:0] b;
    b = {SBOX[a[31:24]], SBOX[a[23:16]], SBOX[a[15:8]], SBOX[a[7:0]]};
    return b ^ {b[29:0], b[31:30]} ^ {b[21:0], b[31:22]}
             ^ {b[13:0], b[31:14]} ^ {b[7:0], b[31:8]};
  endfunction

  // Run all rounds on one block with the current key store.
  function automatic sm4_out_t sm4_rounds(input sm4_in_t item);
    logic [WORD_W-1:0] x0, x1, x2, x3, nx;
    int unsigned       k;
    sm4_out_t          res;
    x0 = item.in_word0;
    x1 = item.in_word1;
    x2 = item.in_word2;
    x3 = item.in_word3;
    for (int unsigned r = 0; r < NUM_ROUNDS; r++) begin
      k  = (item.op == OP_ENCRYPT) ? r : (NUM_ROUNDS - 1 - r);
      nx = x0 ^ mix_word(x1 ^ x2 ^ x3 ^ round_keys[k]);
      x0 = x1;
      x1 = x2;
      x2 = x3;
      x3 = nx;
    end
    res.out_word0 = x3;
    res.out_word1 = x2;
    res.out_word2 = x1;
    res.out_word3 = x0;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    sm4_out_t want;
    if (!rst_ni) begin
      pending_blocks.delete();
      mismatches = 0;
      pending_o <= 0;
      errors_o  <= 0;
    end else begin
      // Retire the output transfer first so a block accepted at this edge
      // can never pair with it.
      if (out_valid_i && !out_stall_i) begin
        if (pending_blocks.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected block %h %h %h %h", $realtime,
                     out_data_i.out_word0, out_data_i.out_word1,
                     out_data_i.out_word2, out_data_i.out_word3);
        end else begin
          want = pending_blocks.pop_front();
          if (want.out_word0 !== out_data_i.out_word0 ||
              want.out_word1 !== out_data_i.out_word1 ||
              want.out_word2 !== out_data_i.out_word2 ||
              want.out_word3 !== out_data_i.out_word3) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: block mismatch", $realtime);
              $display("  expected %h %h %h %h", want.out_word0, want.out_word1,
                       want.out_word2, want.out_word3);
              $display("  actual   %h %h %h %h", out_data_i.out_word0,
                       out_data_i.out_word1, out_data_i.out_word2, out_data_i.out_word3);
            end
          end
        end
      end

      if (in_valid_i && !in_stall_i) begin
        case (in_data_i.op)
          OP_LOAD:                round_keys[in_data_i.key_index] = in_data_i.key_word;
          OP_ENCRYPT, OP_DECRYPT: pending_blocks.push_back(sm4_rounds(in_data_i));
          default:                ;
        endcase
      end

      pending_o <= pending_blocks.size();
      errors_o  <= mismatches;
    end
  end

endmodule

@@ dv/sm4_block_cipher_tb.sv @@
// Top of the SM4 block cipher testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module sm4_block_cipher_tb;

  import sm4_pkg::*;

  // The fourth op code has no meaning; the block must drop it untouched.
  localparam logic [1:0]  OP_UNUSED    = 2'd3;
  localparam int unsigned RANDOM_ITEMS = 500;
  // Leave room for a trailing result and stalls.
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned DRAIN_LIMIT   = 20000;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_stall_o;
  sm4_in_t  in_data_i   = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  sm4_out_t out_data_o;

  int   pending_w;
  int   fail_w;
  // High while the bench inserts no input gaps and no output stalls.
  logic calm = 1'b0;

  int n_load = 0;
  int n_enc  = 0;
  int n_dec  = 0;
  int n_skip = 0;

  sm4_block_cipher DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  sm4_block_cipher_chk u_chk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_i (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_i(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_i (out_data_o),
    .pending_o  (pending_w),
    .errors_o   (fail_w)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Receiver back-pressure: stall at random about 7 percent of the time, never while calm.
  always @(posedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(0, 99) < 7);
  end

  function automatic logic [127:0] rand_block();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  // Present one item and hold it until the block takes it. An optional idle
  // gap goes in front.
  task automatic send(input logic [1:0] op, input logic [KEY_IDX_W-1:0] idx,
                      input logic [WORD_W-1:0] kw, input logic [127:0] blk);
    sm4_in_t item;
    item.op        = op;
    item.key_index = idx;
    item.key_word  = kw;
    item.in_word0  = blk[127:96];
    item.in_word1  = blk[95:64];
    item.in_word2  = blk[63:32];
    item.in_word3  = blk[31:0];
    if (!calm && $urandom_range(0, 99) < 7) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_data_i  <= item;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    case (op)
      OP_LOAD:    n_load++;
      OP_ENCRYPT: n_enc++;
      OP_DECRYPT: n_dec++;
      default:    n_skip++;
    endcase
  endtask

  // Write a fresh random key into every store entry; the block fields carry
  // junk that a load must ignore.
  task automatic load_schedule();
    for (int unsigned i = 0; i < NUM_ROUNDS; i++)
      send(OP_LOAD, KEY_IDX_W'(i), $urandom, rand_block());
  endtask

  // Hold the sender off until every predicted block has come back or the guard runs out.
  task automatic drain();
    int unsigned guard;
    guard = 0;
    @(posedge clk_i);
    while (pending_w != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk_i);
      guard++;
    end
  endtask

  initial begin
    int  r;
    int  sent;
    bit  drained;
    sent    = 0;
    drained = 1'b0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Fill the whole key store before any block reads it.
    load_schedule();

    // Directed: extreme keys at both ends of the store, extreme blocks in
    // both directions, ignored op codes, and ignored fields set to all ones.
    send(OP_LOAD,    KEY_FIRST, '0, '1);
    send(OP_LOAD,    KEY_LAST,  '1, '0);
    send(OP_ENCRYPT, '0, '0, '0);
    send(OP_ENCRYPT, '1, '1, '1);
    send(OP_DECRYPT, '0, '0, '0);
    send(OP_DECRYPT, '1, '1, '1);
    // An unused op that looks like a load of key 31 must not touch it.
    send(OP_UNUSED,  KEY_LAST, 32'h1234_5678, '1);
    send(OP_ENCRYPT, '0, '0, {4{32'h5555_aaaa}});
    send(OP_UNUSED,  KEY_FIRST, '0, '0);
    send(OP_DECRYPT, '0, '0, {4{32'haaaa_5555}});
    send(OP_LOAD,    5'd16, 32'h8000_0001, '1);
    send(OP_ENCRYPT, 5'd16, $urandom, 128'h0123_4567_89ab_cdef_fedc_ba98_7654_3210);
    send(OP_DECRYPT, 5'd16, $urandom, 128'h0123_4567_89ab_cdef_fedc_ba98_7654_3210);
    send(OP_ENCRYPT, '0, '0, 128'h8000_0000_0000_0001_8000_0000_0000_0001);

    // Random mix: mostly blocks, with single key rewrites, occasional full
    // reschedules, and a sprinkling of dropped op codes.
    while (sent < RANDOM_ITEMS) begin
      calm <= (sent >= 150 && sent < 250);
      if (!drained && sent >= 300) begin
        in_valid_i <= 1'b0;
        drain();
        drained = 1'b1;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
        load_schedule();
        sent += NUM_ROUNDS;
      end else if (r < 22) begin
        send(OP_LOAD, KEY_IDX_W'($urandom_range(0, NUM_ROUNDS - 1)), $urandom, rand_block());
        sent++;
      end else if (r < 28) begin
        send(OP_UNUSED, KEY_IDX_W'($urandom), $urandom, rand_block());
      end else if (r < 64) begin
        send(OP_ENCRYPT, KEY_IDX_W'($urandom), $urandom, rand_block());
        sent++;
      end else begin
        send(OP_DECRYPT, KEY_IDX_W'($urandom), $urandom, rand_block());
        sent++;
      end
    end

    in_valid_i <= 1'b0;
    calm       <= 1'b0;
    drain();
    // Give a stray extra block time to show up.
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Covered %0d key loads, %0d encrypts, %0d decrypts, %0d dropped op codes,",
             n_load, n_enc, n_dec, n_skip);
    $display("with random gaps and stalls, a gap-free stretch and one full drain mid-run.");
    if (fail_w == 0 && pending_w == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog: a hang on either channel ends the run here.
  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
